### design/sample_ring_burst_packetizer_top_defines.svh
// Assertion macros for the sample ring burst packetizer.
// Included by the top level; expects clk and rst in scope at the point of use.
`ifndef SAMPLE_RING_BURST_PACKETIZER_TOP_DEFINES_SVH
`define SAMPLE_RING_BURST_PACKETIZER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SRBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srbp assertion failed");

// Antecedent implies consequent in the following cycle.
`define SRBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srbp assertion failed");

`endif

### design/srbp_pkg.sv
// Shared types and constants of the sample ring burst packetizer.
// No dependencies; imported by the controller, the datapath and the top level.
package srbp_pkg;

  localparam logic [2:0] ACT_SAMPLE  = 3'd0;
  localparam logic [2:0] ACT_POLL    = 3'd1;
  localparam logic [2:0] ACT_START   = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_REQUEST = 3'd4;

  localparam logic [1:0] KIND_HDR    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_REPLY  = 2'd2;

  localparam logic [15:0] DIST_LIMIT  = 16'hFF00;
  localparam logic [15:0] RATE_RESET  = 16'd400;
  localparam logic [15:0] PAUSE_RESET = 16'd100;
  localparam logic [15:0] STOP_REPLY  = 16'd1;
  localparam int          MS_PER_S    = 1000;

  // Exact x/100 for any 16-bit x: (x * 83887) >> 23.
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;

  typedef struct packed {
    logic capture;
    logic write_sample;
    logic clear_pause;
    logic set_pause;
    logic start_pkt;
    logic do_start;
    logic do_stop;
    logic do_request;
    logic load_hdr;
    logic issue;
    logic issue_last;
    logic load_reply;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic paused;
    logic pause_expired;
    logic bursts_zero;
    logic dist_ok;
    logic send_ok;
    logic div_done;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

### design/sample_ring_burst_packetizer_top.sv
// Each input item is accepted in ST_IDLE and decoded in ST_DECODE; a sample, request or idle poll ends there.
// A sent packet puts its header out after decode, then one sample per cycle, while the output takes them, from the
// single ring read port, each sample passing the ring read, product and output registers; the packet closes
// only when the 16-step time-step divider is done, which bounds short packets.
// Synchronous reset clears control and burst state; ring contents stay undefined, with no clear pass.
// Top level: joins srbp_ctrl and srbp_datapath; uses srbp_pkg and the assertion macro header.
`include "sample_ring_burst_packetizer_top_defines.svh"

module sample_ring_burst_packetizer_top #(
  parameter int SAMPLES_PER_PACKET = 32,
  parameter int RING_DEPTH         = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] sample_value,
  input  logic [31:0] now_ticks,
  input  logic        send_ok,
  input  logic [15:0] burst_len,
  input  logic [15:0] req_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  seq_num,
  output logic [31:0] start_time,
  output logic [15:0] rate_hz,
  output logic [7:0]  sample_byte,
  output logic [15:0] reply_value,
  output logic        last
);
  import srbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  srbp_ctrl #(
    .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  srbp_datapath #(
    .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET),
    .RING_DEPTH        (RING_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .sample_value (sample_value),
    .now_ticks    (now_ticks),
    .send_ok      (send_ok),
    .burst_len    (burst_len),
    .req_rate     (req_rate),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .seq_num      (seq_num),
    .start_time   (start_time),
    .rate_hz      (rate_hz),
    .sample_byte  (sample_byte),
    .reply_value  (reply_value),
    .last         (last)
  );

  // No new item is taken while samples of a packet are still in the read pipeline.
  `SRBP_ASSERT_IMP(a_ready_pipe_empty, in_ready, status.pipe_empty)
  // Packet state is updated only after the step is known and every sample has left the pipeline.
  `SRBP_ASSERT_IMP(a_finish_safe, cmd.finish, status.div_done && status.pipe_empty)
  // Header, reply, ring read and ring write never compete in one cycle.
  `SRBP_ASSERT_IMP(a_one_source,
    1'b1, $onehot0({cmd.load_hdr, cmd.load_reply, cmd.issue, cmd.write_sample}))
  // A loaded header stands in the output register on the next cycle and is never marked last.
  `SRBP_ASSERT_NEXT(a_hdr_then_sample,
    cmd.load_hdr, out_valid && kind == KIND_HDR && !last)

endmodule

### design/srbp_ctrl.sv
// Controller state machine of the sample ring burst packetizer.
// Depends on srbp_pkg; drives the datapath through cmd_t and reads status_t.
module srbp_ctrl #(
  parameter int SAMPLES_PER_PACKET = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  srbp_pkg::status_t status,
  output srbp_pkg::cmd_t    cmd
);
  import srbp_pkg::*;

  localparam int CW = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(SAMPLES_PER_PACKET - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REPLY,
    ST_HDR,
    ST_ISSUE,
    ST_FIN
  } state_t;

  state_t        state;
  logic [2:0]    act;
  logic [CW-1:0] cnt;
  logic          poll_go;

  assign in_ready = (state == ST_IDLE);

  // A poll sends a packet only when not paused, a burst runs, a packet is
  // complete in the ring and the transport takes it.
  assign poll_go = !status.paused && !status.bursts_zero && status.dist_ok && status.send_ok;

  always_comb begin
    cmd = '0;
    cmd.capture     = (state == ST_IDLE) && in_valid;
    cmd.load_reply  = (state == ST_REPLY) && status.out_free;
    cmd.load_hdr    = (state == ST_HDR) && status.out_free;
    cmd.issue       = (state == ST_ISSUE) && status.out_free;
    cmd.issue_last  = (cnt == CNT_LAST);
    cmd.finish      = (state == ST_FIN) && status.div_done && status.pipe_empty;
    if (state == ST_DECODE) begin
      unique case (act)
        ACT_SAMPLE:  cmd.write_sample = 1'b1;
        ACT_POLL: begin
          cmd.clear_pause = status.paused && status.pause_expired;
          cmd.set_pause   = !status.paused && !status.bursts_zero && status.dist_ok &&
                            !status.send_ok;
          cmd.start_pkt   = poll_go;
        end
        ACT_START:   cmd.do_start   = 1'b1;
        ACT_STOP:    cmd.do_stop    = 1'b1;
        ACT_REQUEST: cmd.do_request = 1'b1;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      act   <= ACT_SAMPLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act   <= action;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (act) inside
            ACT_POLL:           state <= poll_go ? ST_HDR : ST_IDLE;
            ACT_START, ACT_STOP: state <= ST_REPLY;
            default:            state <= ST_IDLE;
          endcase
        end
        ST_REPLY: begin
          if (status.out_free) state <= ST_IDLE;
        end
        ST_HDR: begin
          if (status.out_free) begin
            cnt   <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (status.out_free) begin
            if (cnt == CNT_LAST) begin
              state <= ST_FIN;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (status.div_done && status.pipe_empty) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/srbp_datapath.sv
// Datapath of the sample ring burst packetizer: ring memory, burst state,
// sample read pipeline, time-step divider and output register. Uses srbp_pkg.
module srbp_datapath #(
  parameter int SAMPLES_PER_PACKET = 32,
  parameter int RING_DEPTH         = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic [15:0]       sample_value,
  input  logic [31:0]       now_ticks,
  input  logic              send_ok,
  input  logic [15:0]       burst_len,
  input  logic [15:0]       req_rate,
  input  srbp_pkg::cmd_t    cmd,
  output srbp_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [7:0]        seq_num,
  output logic [31:0]       start_time,
  output logic [15:0]       rate_hz,
  output logic [7:0]        sample_byte,
  output logic [15:0]       reply_value,
  output logic              last
);
  import srbp_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 1;
  localparam logic [AW-1:0] PTR_LAST  = AW'(RING_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_W   = PW'(RING_DEPTH);
  localparam logic [15:0]   SPP16     = 16'(SAMPLES_PER_PACKET);
  localparam logic [15:0]   DIVIDEND  = 16'(MS_PER_S * SAMPLES_PER_PACKET);

  // Ring pointers follow the 16-bit indices modulo the ring depth.
  function automatic logic [AW-1:0] ptr_inc(input logic [15:0] val,
                                            input logic [AW-1:0] ptr);
    if (val == 16'hFFFF) return '0;
    else if (ptr == PTR_LAST) return '0;
    else return ptr + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [15:0] val,
                                            input logic [AW-1:0] ptr);
    logic [16:0]   sum;
    logic [PW-1:0] psum;
    sum  = {1'b0, val} + 17'(SAMPLES_PER_PACKET);
    psum = {1'b0, ptr} + PW'(SAMPLES_PER_PACKET);
    // When the 16-bit index wraps, the new index is below the packet size.
    if (sum[16]) return sum[AW-1:0];
    else if (psum >= DEPTH_W) return AW'(psum - DEPTH_W);
    else return psum[AW-1:0];
  endfunction

  logic [15:0] ring [RING_DEPTH];

  logic [15:0]   sample_q;
  logic [31:0]   now_q;
  logic          send_ok_q;
  logic [15:0]   blen_q;
  logic [15:0]   rate_q;

  logic [15:0]   pause_ticks;
  logic [15:0]   head;
  logic [AW-1:0] head_ptr;
  logic [15:0]   mark;
  logic [AW-1:0] mark_ptr;
  logic [15:0]   pstart;
  logic [AW-1:0] pstart_ptr;
  logic [15:0]   bursts_left;
  logic          paused;
  logic [31:0]   pause_until;
  logic [31:0]   time_stamp;
  logic [15:0]   current_rate;
  logic [7:0]    sequence_num;
  logic [15:0]   reply_q;

  logic [15:0]   rd_idx;
  logic [AW-1:0] rd_ptr;
  logic [15:0]   rd_data;
  logic          valid_b;
  logic          last_b;
  logic [32:0]   prod;
  logic          valid_c;
  logic          last_c;

  logic          div_busy;
  logic [4:0]    div_cnt;
  logic [15:0]   div_rem;
  logic [15:0]   div_quo;
  logic [15:0]   divisor;
  logic [16:0]   trial;

  logic          adv;
  logic [15:0]   mark_gap;

  assign adv      = !out_valid || out_ready;
  assign mark_gap = head - mark;
  assign trial    = {div_rem, div_quo[15]};

  assign status.paused        = paused;
  assign status.pause_expired = (pause_until < now_q);
  assign status.bursts_zero   = (bursts_left == 16'd0);
  assign status.dist_ok       = (mark_gap != 16'd0) && (mark_gap < DIST_LIMIT);
  assign status.send_ok       = send_ok_q;
  assign status.div_done      = !div_busy;
  assign status.pipe_empty    = !valid_b && !valid_c;
  assign status.out_free      = adv;

  // Input item and ring memory.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q  <= sample_value;
      now_q     <= now_ticks;
      send_ok_q <= send_ok;
      blen_q    <= burst_len;
      rate_q    <= req_rate;
    end
    if (cmd.write_sample) ring[head_ptr] <= sample_q;
    if (adv) rd_data <= ring[rd_ptr];
  end

  // Burst state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_ticks  <= PAUSE_RESET;
      head         <= '0;
      head_ptr     <= '0;
      mark         <= SPP16;
      mark_ptr     <= AW'(SAMPLES_PER_PACKET);
      pstart       <= '0;
      pstart_ptr   <= '0;
      bursts_left  <= '0;
      paused       <= 1'b0;
      pause_until  <= '0;
      time_stamp   <= '0;
      current_rate <= RATE_RESET;
      sequence_num <= '0;
    end else begin
      if (cfg_we) pause_ticks <= cfg_data;
      if (cmd.write_sample) begin
        head     <= head + 16'd1;
        head_ptr <= ptr_inc(head, head_ptr);
      end
      if (cmd.clear_pause) paused <= 1'b0;
      if (cmd.set_pause) begin
        paused      <= 1'b1;
        pause_until <= now_q + {16'd0, pause_ticks};
      end
      if (cmd.do_start && status.bursts_zero) begin
        sequence_num <= '0;
        head         <= '0;
        head_ptr     <= '0;
        pstart       <= '0;
        pstart_ptr   <= '0;
        mark         <= SPP16;
        mark_ptr     <= AW'(SAMPLES_PER_PACKET);
        bursts_left  <= blen_q;
      end
      if (cmd.do_stop && !status.bursts_zero) begin
        bursts_left <= '0;
        head        <= '0;
        head_ptr    <= '0;
        mark        <= SPP16;
        mark_ptr    <= AW'(SAMPLES_PER_PACKET);
      end
      if (cmd.do_request) begin
        current_rate <= rate_q;
        time_stamp   <= now_q;
        pstart       <= head;
        pstart_ptr   <= head_ptr;
        mark         <= head + SPP16;
        mark_ptr     <= ptr_add(head, head_ptr);
      end
      if (cmd.load_hdr) sequence_num <= sequence_num + 8'd1;
      if (cmd.finish) begin
        bursts_left <= bursts_left - 16'd1;
        mark        <= mark + SPP16;
        mark_ptr    <= ptr_add(mark, mark_ptr);
        pstart      <= mark;
        pstart_ptr  <= mark_ptr;
        if (divisor != 16'd0) time_stamp <= time_stamp + {16'd0, div_quo};
      end
    end
  end

  // Reply value, latched while the command is decoded.
  always_ff @(posedge clk) begin
    if (cmd.do_start) reply_q <= status.bursts_zero ? blen_q : 16'd0;
    if (cmd.do_stop)  reply_q <= STOP_REPLY;
  end

  // Restoring divider for the per-packet time step, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.start_pkt) begin
      div_busy <= 1'b1;
      div_cnt  <= 5'd16;
    end else if (div_busy) begin
      div_cnt <= div_cnt - 5'd1;
      if (div_cnt == 5'd1) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_pkt) begin
      div_rem <= '0;
      div_quo <= DIVIDEND;
      divisor <= current_rate;
    end else if (div_busy) begin
      if (trial >= {1'b0, divisor}) begin
        div_rem <= 16'(trial - {1'b0, divisor});
        div_quo <= {div_quo[14:0], 1'b1};
      end else begin
        div_rem <= trial[15:0];
        div_quo <= {div_quo[14:0], 1'b0};
      end
    end
  end

  // Read pointer; the whole sample pipeline moves only when the output can take.
  always_ff @(posedge clk) begin
    if (cmd.start_pkt) begin
      rd_idx <= pstart;
      rd_ptr <= pstart_ptr;
    end else if (cmd.issue) begin
      rd_idx <= rd_idx + 16'd1;
      rd_ptr <= ptr_inc(rd_idx, rd_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      valid_b   <= cmd.issue;
      valid_c   <= valid_b;
      out_valid <= cmd.load_hdr || cmd.load_reply || valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_b <= cmd.issue_last;
      last_c <= last_b;
      prod   <= rd_data * DIV100_MUL;
      if (cmd.load_hdr) begin
        kind        <= KIND_HDR;
        seq_num     <= sequence_num;
        start_time  <= time_stamp;
        rate_hz     <= current_rate;
        sample_byte <= '0;
        reply_value <= '0;
        last        <= 1'b0;
      end else if (cmd.load_reply) begin
        kind        <= KIND_REPLY;
        seq_num     <= '0;
        start_time  <= '0;
        rate_hz     <= '0;
        sample_byte <= '0;
        reply_value <= reply_q;
        last        <= 1'b1;
      end else begin
        kind        <= KIND_SAMPLE;
        seq_num     <= '0;
        start_time  <= '0;
        rate_hz     <= '0;
        sample_byte <= prod[DIV100_SHIFT +: 8];
        reply_value <= '0;
        last        <= last_c;
      end
    end
  end

endmodule
